// ----- sv/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the streaming linear convolution block.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int unsigned DataW     = 16;
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned AccW      = 35;
  localparam int unsigned NumCoef   = 5;
  localparam int unsigned CoefIdxW  = 3;
  localparam int unsigned TapsDef   = 5;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic signed [DataW-1:0] data_t;
  typedef data_t [NumCoef-1:0] coef_arr_t;

  // one operation for the datapath: a sample to push, with end-of-signal mark
  typedef struct packed {
    data_t value;
    logic  last;
  } lcs_op_t;

endpackage

// ----- sv/lcs_front.sv -----
// ----------------------------------------------------------------------------
// lcs_front
// Accepts samples and expands a final sample into its zero-fed tail.
// ----------------------------------------------------------------------------
module lcs_front
  import lcs_pkg::*;
#(
  parameter int unsigned TAPS = TapsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  data_t   sample_i,
  input  logic    final_sample_i,
  input  logic    fifo_full_i,
  output logic    push_o,
  output lcs_op_t op_o
);

  localparam int unsigned CntW = $clog2(TAPS);

  logic [CntW-1:0] tail_cnt_q, tail_cnt_d;
  logic            tail_active;
  logic            accept;

  assign tail_active = (tail_cnt_q != '0);
  assign in_stall_o  = tail_active || fifo_full_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    tail_cnt_d = tail_cnt_q;
    push_o     = 1'b0;
    op_o.value = sample_i;
    op_o.last  = 1'b0;
    if (tail_active) begin
      // zero beats that flush the delay line, last one closes the signal
      op_o.value = '0;
      op_o.last  = (tail_cnt_q == CntW'(1));
      if (!fifo_full_i) begin
        push_o     = 1'b1;
        tail_cnt_d = tail_cnt_q - 1'b1;
      end
    end else if (accept) begin
      push_o = 1'b1;
      if (final_sample_i) begin
        tail_cnt_d = CntW'(TAPS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_cnt_q <= '0;
    end else begin
      tail_cnt_q <= tail_cnt_d;
    end
  end

endmodule

// ----- sv/lcs_fifo.sv -----
// ----------------------------------------------------------------------------
// lcs_fifo
// Short queue of operations between the front and the datapath.
// ----------------------------------------------------------------------------
module lcs_fifo
  import lcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  lcs_op_t push_data_i,
  input  logic    pop_i,
  output lcs_op_t pop_data_o,
  output logic    full_o,
  output logic    empty_o
);

  lcs_op_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o     = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/lcs_back.sv -----
// ----------------------------------------------------------------------------
// lcs_back
// Delay line, tap multipliers and adder tree with a registered output beat.
// ----------------------------------------------------------------------------
module lcs_back
  import lcs_pkg::*;
#(
  parameter int unsigned TAPS = TapsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  coef_arr_t              coef_i,
  input  logic                   fifo_empty_i,
  input  lcs_op_t                op_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AccW-1:0] conv_value_o,
  output logic                   conv_last_o
);

  localparam int unsigned HistD = TAPS - 1;

  data_t                   hist_q [HistD];
  data_t                   taps_in [TAPS];
  logic signed [ProdW-1:0] prod_q [TAPS];
  logic                    prod_valid_q, prod_last_q;
  logic signed [AccW-1:0]  sum;
  logic signed [AccW-1:0]  out_value_q;
  logic                    out_valid_q, out_last_q;
  logic                    advance;

  // whole pipeline holds only while a finished beat is stalled
  assign advance = !(out_valid_q && out_stall_i);
  assign pop_o   = advance && !fifo_empty_i;

  always_comb begin
    taps_in[0] = op_i.value;
    for (int k = 1; k < TAPS; k++) begin
      taps_in[k] = hist_q[k-1];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + AccW'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistD; i++) begin
        hist_q[i] <= '0;
      end
    end else if (pop_o) begin
      hist_q[0] <= op_i.value;
      for (int i = 1; i < HistD; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_q[k] <= coef_i[k] * taps_in[k];
      end
      prod_last_q <= op_i.last;
      out_value_q <= sum;
      out_last_q  <= prod_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      prod_valid_q <= pop_o;
      out_valid_q  <= prod_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign conv_value_o = out_value_q;
  assign conv_last_o  = out_last_q;

endmodule

// ----- sv/linear_convolution_stream.sv -----
// ----------------------------------------------------------------------------
// linear_convolution_stream
// Streaming full linear convolution of a sample stream with a short kernel.
// ----------------------------------------------------------------------------
// Usage:
//   Kernel taps coef_0..coef_4 are written over the cfg channel (index 0..4,
//   other indexes are ignored); cfg_ready_o is always high. Write taps only
//   while no signal is in flight.
//   Samples enter on in_valid_i/in_stall_o, one beat per cycle while
//   in_stall_o is low. Each sample gives one result beat; a beat with
//   final_sample_i set is followed by TAPS-1 tail results and the last of
//   these carries conv_last_o. While the tail is generated the input is
//   stalled. An accepted sample passes through the queue entry, the tap
//   product registers and the adder tree into the output register.
//   Throughput is one result per cycle while out_stall_i is low, set by the
//   single product stage and single adder stage. A 4-entry queue decouples
//   input from the datapath; when out_stall_i holds the output beat the
//   datapath freezes and the queue keeps accepting samples until it fills.
//   Reset clears the taps to zero, the delay line, the queue and all valids.
// ----------------------------------------------------------------------------
module linear_convolution_stream
  import lcs_pkg::*;
#(
  parameter int unsigned TAPS = TapsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CoefIdxW-1:0]    cfg_index_i,
  input  data_t                  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  data_t                  sample_i,
  input  logic                   final_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AccW-1:0] conv_value_o,
  output logic                   conv_last_o
);

  coef_arr_t coef_q;
  lcs_op_t   push_op, pop_op;
  logic      push, pop, fifo_full, fifo_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CoefIdxW'(NumCoef))) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  lcs_front #(
    .TAPS (TAPS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .final_sample_i (final_sample_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .op_o           (push_op)
  );

  lcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .pop_i       (pop),
    .pop_data_o  (pop_op),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  lcs_back #(
    .TAPS (TAPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef_q),
    .fifo_empty_i (fifo_empty),
    .op_i         (pop_op),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .conv_value_o (conv_value_o),
    .conv_last_o  (conv_last_o)
  );

endmodule
